### hw/rtl/lkvc_pkg.sv
// Types and constants shared by the LRU key-value cache modules.
package lkvc_pkg;

   localparam int KEY_W = 32;
   localparam int VAL_W = 31;
   localparam int CAP_W = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_PUT = 1'b1;

   // One stored entry as it moves down the row of cells.
   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } lkvc_entry_type;

   // Hit search result travelling from the oldest cell towards the front.
   typedef struct packed {
      logic             found;
      logic [VAL_W-1:0] value;
   } lkvc_probe_type;

   // Broadcast control from the sequencer to every cell.
   typedef struct packed {
      logic capture;
      logic update;
      logic is_put;
      logic hit;
      logic full;
   } lkvc_ctrl_type;

endpackage

### hw/rtl/lkvc_if.sv
// Handshake channel interfaces for requests, responses and the capacity register.
interface lkvc_req_if import lkvc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             func;
   logic [KEY_W-1:0] key;
   logic [VAL_W-1:0] value;

   modport source (output valid, output func, output key, output value, input ready);
   modport sink   (input valid, input func, input key, input value, output ready);
endinterface

interface lkvc_rsp_if import lkvc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             hit;
   logic [VAL_W-1:0] read_value;

   modport source (output valid, output hit, output read_value, input ready);
   modport sink   (input valid, input hit, input read_value, output ready);
endinterface

interface lkvc_csr_if import lkvc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CAP_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/lkvc_cell.sv
// One recency slot of the cache: holds an entry, compares its key and shifts towards the back.
module lkvc_cell import lkvc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  lkvc_ctrl_type    ctrl,
   input  logic [KEY_W-1:0] lookup_key,
   input  lkvc_entry_type   left_entry,
   output lkvc_entry_type   right_entry,
   input  lkvc_probe_type   probe_in,
   output lkvc_probe_type   probe_out
);

   lkvc_entry_type entry_ff, entry_in;
   logic           match_ff, match_in;
   logic           shift;

   // A hit moves every cell from the front up to the hit cell; an insert moves every
   // occupied cell, plus the first free one when there is room.
   always_comb begin
      shift = 1'b0;
      if (ctrl.update) begin
         if (ctrl.hit) begin
            shift = probe_out.found;
         end else if (ctrl.is_put) begin
            shift = ctrl.full ? entry_ff.valid : (entry_ff.valid | left_entry.valid);
         end
      end
   end

   always_comb begin
      entry_in = shift ? left_entry : entry_ff;
      match_in = ctrl.capture ? (entry_ff.valid && (entry_ff.key == lookup_key)) : match_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
         match_ff       <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
         match_ff       <= match_in;
      end
      entry_ff.key   <= entry_in.key;
      entry_ff.value <= entry_in.value;
   end

   assign probe_out.found = match_ff | probe_in.found;
   assign probe_out.value = match_ff ? entry_ff.value : probe_in.value;
   assign right_entry     = entry_ff;

endmodule

### hw/rtl/lru_key_value_cache.sv
// Top level of the fully associative LRU key-value cache built as a row of recency cells.
//
//  Channel | Direction | Payload                 | Notes
//  req_chan| in        | func, key, value        | get or put
//  rsp_chan| out       | hit, read_value         | one transfer per get, none per put
//  csr_chan| in        | data (capacity)         | always ready
//
// Every request passes through two states: the key is compared in all cells as it is accepted,
// and the row shifts in the update state; no new request is taken until that shift is done.
// A get stays in its update state while the previous response has not been transferred.
// Reset empties every cell and sets the capacity to sixteen; no clearing pass is needed.
// Cell 0 holds the most recent entry; the oldest valid entry sits at the end of the run.
module lru_key_value_cache import lkvc_pkg::*; #(
   parameter int ENTRIES = 16
) (
   input logic       clock,
   input logic       reset,
   lkvc_req_if.sink  req_chan,
   lkvc_rsp_if.source rsp_chan,
   lkvc_csr_if.sink  csr_chan
);

   localparam int OCC_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

   typedef enum logic {ST_IDLE, ST_UPDATE} state_type;

   state_type        state_ff;
   logic             op_put_ff;
   logic [KEY_W-1:0] op_key_ff;
   logic [VAL_W-1:0] op_value_ff;
   logic [OCC_W-1:0] occ_ff;
   logic [CAP_W-1:0] capacity_ff;
   logic             rsp_valid_ff;
   logic             rsp_hit_ff;
   logic [VAL_W-1:0] rsp_value_ff;

   lkvc_ctrl_type    ctrl;
   lkvc_entry_type   entry_chain [0:ENTRIES];
   lkvc_probe_type   probe_chain [0:ENTRIES];
   logic [ENTRIES-1:0] valid_vec;
   logic [KEY_W-1:0] lookup_key;
   logic             req_xfer;
   logic             rsp_free;
   logic             update_go;
   logic [CMP_W-1:0] cap_ext;
   logic [CMP_W-1:0] eff_cap;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_xfer       = req_chan.valid & req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign rsp_free  = !rsp_valid_ff || rsp_chan.ready;
   assign update_go = (state_ff == ST_UPDATE) && (op_put_ff || rsp_free);

   // Capacity of zero behaves as one and anything above the cell count as the cell count.
   always_comb begin
      cap_ext = CMP_W'(capacity_ff);
      if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign lookup_key   = req_chan.key;
   assign ctrl.capture = req_xfer;
   assign ctrl.update  = update_go;
   assign ctrl.is_put  = op_put_ff;
   assign ctrl.hit     = probe_chain[0].found;
   assign ctrl.full    = CMP_W'(occ_ff) >= eff_cap;

   // The front of the row is fed with the entry that becomes most recent.
   assign entry_chain[0].valid = 1'b1;
   assign entry_chain[0].key   = op_key_ff;
   assign entry_chain[0].value = op_put_ff ? op_value_ff : probe_chain[0].value;
   assign probe_chain[ENTRIES] = '0;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      lkvc_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .lookup_key  (lookup_key),
         .left_entry  (entry_chain[g]),
         .right_entry (entry_chain[g+1]),
         .probe_in    (probe_chain[g+1]),
         .probe_out   (probe_chain[g])
      );
      assign valid_vec[g] = entry_chain[g+1].valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         capacity_ff  <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            capacity_ff <= csr_chan.data;
         end
         // A new response may replace the one being transferred in the same cycle.
         if (update_go && !op_put_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  state_ff <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               if (update_go) begin
                  state_ff <= ST_IDLE;
                  if (op_put_ff && !ctrl.hit && !ctrl.full) begin
                     occ_ff <= occ_ff + OCC_W'(1);
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
      if (req_xfer) begin
         op_put_ff   <= (req_chan.func == FUNC_PUT);
         op_key_ff   <= req_chan.key;
         op_value_ff <= req_chan.value;
      end
      if (update_go && !op_put_ff) begin
         rsp_hit_ff   <= probe_chain[0].found;
         rsp_value_ff <= probe_chain[0].found ? probe_chain[0].value : '0;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.hit        = rsp_hit_ff;
   assign rsp_chan.read_value = rsp_value_ff;

   a_occ_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(occ_ff))
      else $error("occupancy count disagrees with the valid cells");

   a_rsp_from_get: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(state_ff == ST_UPDATE && !op_put_ff))
      else $error("response raised without a get being applied");

   a_put_fills_front: assert property (@(posedge clock) disable iff (reset)
      (update_go && op_put_ff) |=> valid_vec[0])
      else $error("front cell not valid after a put");

endmodule
